// ----- src/vmfs_pkg.sv -----
// Package for the gate valve mode and feedback supervisor.
// Holds the mode codes, request bit positions, register indexes and shared structs.
// No dependencies.
`timescale 1ns / 1ps

package vmfs_pkg;

  localparam int TimerWidthDefault = 8;
  localparam int ReloadWidth = 8;
  localparam int CfgIndexWidth = 2;
  localparam int TimerResetValue = 50;
  localparam logic [ReloadWidth-1:0] WaitReloadReset = 8'd10;

  typedef enum logic [1:0] {
    MODE_AUTO   = 2'd0,
    MODE_OPER   = 2'd1,
    MODE_REMOTE = 2'd2
  } mode_t;

  // Configuration register indexes.
  localparam logic [CfgIndexWidth-1:0] CFG_WAIT_RELOAD    = 2'd0;
  localparam logic [CfgIndexWidth-1:0] CFG_PRESS_ENABLE   = 2'd1;
  localparam logic [CfgIndexWidth-1:0] CFG_POSITION_ENABLE = 2'd2;
  localparam logic [CfgIndexWidth-1:0] CFG_OS_ENABLE      = 2'd3;

  // Pending request bit positions.
  localparam int P_OPEN   = 0;
  localparam int P_CLOSE  = 1;
  localparam int P_ACK    = 2;
  localparam int P_AUTO   = 3;
  localparam int P_OPER   = 4;
  localparam int P_REMOTE = 5;
  localparam int PendingWidth = 6;

  typedef struct packed {
    logic [ReloadWidth-1:0] wait_reload;
    logic                   press_check_enable;
    logic                   position_check_enable;
    logic                   os_check_enable;
  } cfg_t;

  typedef struct packed {
    logic                    commanded_open;
    mode_t                   control_mode;
    logic [PendingWidth-1:0] pending_requests;
    logic                    feedback_error_flag;
    logic                    os_error_flag;
  } ctrl_state_t;

  typedef struct packed {
    logic key_open;
    logic key_close;
    logic key_ack_error;
    logic key_auto;
    logic key_operator;
    logic remote_request;
    logic press_sense;
    logic position_sense;
    logic os_sense;
    logic second_tick;
  } scan_item_t;

endpackage

// ----- src/vmfs_if.sv -----
// Channel interfaces for the valve supervisor: scan inputs and scan results.
// Each carries valid, ready and the payload; no package dependency.
`timescale 1ns / 1ps

interface vmfs_in_if;
  logic valid;
  logic ready;
  logic key_open;
  logic key_close;
  logic key_ack_error;
  logic key_auto;
  logic key_operator;
  logic remote_request;
  logic press_sense;
  logic position_sense;
  logic os_sense;
  logic second_tick;

  modport source (
    output valid, key_open, key_close, key_ack_error, key_auto, key_operator,
           remote_request, press_sense, position_sense, os_sense, second_tick,
    input  ready
  );
  modport sink (
    input  valid, key_open, key_close, key_ack_error, key_auto, key_operator,
           remote_request, press_sense, position_sense, os_sense, second_tick,
    output ready
  );
endinterface

interface vmfs_out_if;
  logic       valid;
  logic       ready;
  logic       drive_open;
  logic [1:0] mode;
  logic       feedback_error;
  logic       os_error;

  modport source (
    output valid, drive_open, mode, feedback_error, os_error,
    input  ready
  );
  modport sink (
    input  valid, drive_open, mode, feedback_error, os_error,
    output ready
  );
endinterface

// ----- src/vmfs_scan.sv -----
// Combinational next-state logic for one control scan of the valve supervisor.
// Depends on vmfs_pkg for the state, configuration and item structs.
`timescale 1ns / 1ps

module vmfs_scan #(
  parameter int TIMER_WIDTH = vmfs_pkg::TimerWidthDefault
) (
  input  vmfs_pkg::ctrl_state_t   cur,
  input  logic [TIMER_WIDTH-1:0]  timer,
  input  vmfs_pkg::cfg_t          cfg,
  input  vmfs_pkg::scan_item_t    item,
  output vmfs_pkg::ctrl_state_t   nxt,
  output logic [TIMER_WIDTH-1:0]  timer_next
);
  import vmfs_pkg::*;

  logic [TIMER_WIDTH-1:0]  reload_value;
  logic [PendingWidth-1:0] pend;
  logic                    open_cmd;
  mode_t                   mode_new;
  logic                    ferr;
  logic                    press_reload;
  logic                    pos_reload;
  logic [TIMER_WIDTH-1:0]  t_mid;
  logic                    ferr_mid;

  assign reload_value = TIMER_WIDTH'(cfg.wait_reload);

  always_comb begin
    pend     = cur.pending_requests;
    open_cmd = cur.commanded_open;
    mode_new = cur.control_mode;
    ferr     = cur.feedback_error_flag;

    // Requests latch according to the mode at the start of the scan.
    case (cur.control_mode)
      MODE_OPER: begin
        pend[P_OPEN]  = pend[P_OPEN]  | item.key_open;
        pend[P_CLOSE] = pend[P_CLOSE] | item.key_close;
        pend[P_ACK]   = pend[P_ACK]   | item.key_ack_error;
        pend[P_AUTO]  = pend[P_AUTO]  | item.key_auto;
      end
      MODE_AUTO: begin
        pend[P_OPER] = pend[P_OPER] | item.key_operator;
      end
      default: begin
        pend[P_AUTO] = pend[P_AUTO] | item.key_auto;
      end
    endcase
    pend[P_REMOTE] = pend[P_REMOTE] | item.remote_request;

    if (cur.control_mode != MODE_AUTO) begin
      // Open applies before close, so both pending leaves the valve closed.
      if (pend[P_OPEN]) begin
        open_cmd     = 1'b1;
        pend[P_OPEN] = 1'b0;
      end
      if (pend[P_CLOSE]) begin
        open_cmd      = 1'b0;
        pend[P_CLOSE] = 1'b0;
      end
      if (pend[P_AUTO]) begin
        mode_new     = MODE_AUTO;
        pend[P_AUTO] = 1'b0;
      end
      if (pend[P_ACK]) begin
        ferr        = 1'b0;
        pend[P_ACK] = 1'b0;
      end
    end else if (pend[P_OPER]) begin
      mode_new     = MODE_OPER;
      pend[P_OPER] = 1'b0;
    end else if (pend[P_REMOTE]) begin
      mode_new       = MODE_REMOTE;
      pend[P_REMOTE] = 1'b0;
    end
  end

  assign press_reload = open_cmd ? item.press_sense : ~item.press_sense;
  assign pos_reload   = open_cmd ? ~item.position_sense : item.position_sense;

  // The two timer checks run one after the other on the shared timer.
  always_comb begin
    t_mid    = timer;
    ferr_mid = ferr;
    if (cfg.press_check_enable) begin
      if (press_reload) t_mid = reload_value;
      if (item.second_tick && (t_mid != '0)) t_mid = t_mid - 1'b1;
      if (t_mid == '0) ferr_mid = 1'b1;
    end
    timer_next          = t_mid;
    nxt.feedback_error_flag = ferr_mid;
    if (cfg.position_check_enable) begin
      if (pos_reload) timer_next = reload_value;
      if (item.second_tick && (timer_next != '0)) timer_next = timer_next - 1'b1;
      if (timer_next == '0) nxt.feedback_error_flag = 1'b1;
    end
    nxt.commanded_open   = open_cmd;
    nxt.control_mode     = mode_new;
    nxt.pending_requests = pend;
    nxt.os_error_flag    = cfg.os_check_enable ? ~item.os_sense : cur.os_error_flag;
  end

endmodule

// ----- src/valve_mode_and_feedback_supervisor_unit.sv -----
// Gate valve mode and feedback supervisor: one control scan per input transaction.
// A result is registered and presented in the cycle after its input transaction is accepted.
// Throughput: one scan per cycle while the result side is ready; the output register frees as its result is taken.
// Reset (synchronous, active high): valve closed, auto mode, no pending requests,
// feedback timer at 50 (masked to the timer width), both error flags clear,
// configuration at its reset values, no result pending.
`timescale 1ns / 1ps

module valve_mode_and_feedback_supervisor_unit #(
  parameter int TIMER_WIDTH = vmfs_pkg::TimerWidthDefault
) (
  input  logic                                clk,
  input  logic                                rst,
  vmfs_in_if.sink                             scan_in,
  vmfs_out_if.source                          scan_out,
  input  logic                                cfg_we,
  input  logic [vmfs_pkg::CfgIndexWidth-1:0]  cfg_index,
  input  logic [vmfs_pkg::ReloadWidth-1:0]    cfg_data
);
  import vmfs_pkg::*;

  cfg_t                   cfg;
  ctrl_state_t            state;
  ctrl_state_t            state_next;
  logic [TIMER_WIDTH-1:0] wait_timer;
  logic [TIMER_WIDTH-1:0] wait_timer_next;
  scan_item_t             item;
  logic                   accept;
  logic                   out_valid;

  assign item = '{
    key_open:       scan_in.key_open,
    key_close:      scan_in.key_close,
    key_ack_error:  scan_in.key_ack_error,
    key_auto:       scan_in.key_auto,
    key_operator:   scan_in.key_operator,
    remote_request: scan_in.remote_request,
    press_sense:    scan_in.press_sense,
    position_sense: scan_in.position_sense,
    os_sense:       scan_in.os_sense,
    second_tick:    scan_in.second_tick
  };

  // A new transaction is taken whenever the result register is empty or being drained.
  assign scan_in.ready = ~out_valid | scan_out.ready;
  assign accept        = scan_in.valid & scan_in.ready;

  vmfs_scan #(
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_scan (
    .cur        (state),
    .timer      (wait_timer),
    .cfg        (cfg),
    .item       (item),
    .nxt        (state_next),
    .timer_next (wait_timer_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wait_reload           <= WaitReloadReset;
      cfg.press_check_enable    <= 1'b0;
      cfg.position_check_enable <= 1'b0;
      cfg.os_check_enable       <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WAIT_RELOAD:     cfg.wait_reload           <= cfg_data;
        CFG_PRESS_ENABLE:    cfg.press_check_enable    <= cfg_data[0];
        CFG_POSITION_ENABLE: cfg.position_check_enable <= cfg_data[0];
        CFG_OS_ENABLE:       cfg.os_check_enable       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.commanded_open      <= 1'b0;
      state.control_mode        <= MODE_AUTO;
      state.pending_requests    <= '0;
      state.feedback_error_flag <= 1'b0;
      state.os_error_flag       <= 1'b0;
      wait_timer                <= TIMER_WIDTH'(TimerResetValue);
    end else if (accept) begin
      state      <= state_next;
      wait_timer <= wait_timer_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (scan_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  // The result fields mirror the control state after the last accepted scan.
  assign scan_out.valid          = out_valid;
  assign scan_out.drive_open     = state.commanded_open;
  assign scan_out.mode           = state.control_mode;
  assign scan_out.feedback_error = state.feedback_error_flag;
  assign scan_out.os_error       = state.os_error_flag;

`ifndef ASSERT_OFF
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> scan_out.valid)
    else $error("accepted scan produced no result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (scan_out.valid && !scan_out.ready) |-> !scan_in.ready)
    else $error("input taken while a result is stalled");

  a_timeout_sets_error: assert property (@(posedge clk) disable iff (rst)
    (accept && (cfg.press_check_enable || cfg.position_check_enable))
      |=> ((wait_timer != '0) || state.feedback_error_flag))
    else $error("timer reached zero without a feedback error");

  a_os_tracks: assert property (@(posedge clk) disable iff (rst)
    (accept && cfg.os_check_enable) |=> (state.os_error_flag == !$past(scan_in.os_sense)))
    else $error("OS error does not follow the sensor");
`endif

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for valve_mode_and_feedback_supervisor_unit.
// Drives scan transactions, predicts every status result in a local scan model and
// compares them field by field. Needs vmfs_pkg and the vmfs_in_if/vmfs_out_if interfaces.

module tb_top;
  import vmfs_pkg::*;

  localparam int TimerWidth = TimerWidthDefault;
  localparam int StallLimit = 2000;
  localparam int HoldOffCycles = 60;
  localparam int ReportLimit = 10;
  localparam int RandomPhases = 8;
  localparam int ScansPerPhase = 55;

  typedef struct packed {
    logic       drive_open;
    logic [1:0] mode;
    logic       feedback_error;
    logic       os_error;
  } valve_status_t;

  logic                     clk;
  logic                     rst;
  logic                     cfg_we;
  logic [CfgIndexWidth-1:0] cfg_index;
  logic [ReloadWidth-1:0]   cfg_data;

  vmfs_in_if  scan_in_ch ();
  vmfs_out_if scan_out_ch ();

  valve_mode_and_feedback_supervisor_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .scan_in  (scan_in_ch),
    .scan_out (scan_out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Scan model state and its copy of the configuration registers.
  logic [ReloadWidth-1:0]  reload_ticks;
  logic                    press_chk_on;
  logic                    pos_chk_on;
  logic                    os_chk_on;
  logic                    valve_open;
  mode_t                   ctrl_mode;
  logic [PendingWidth-1:0] pending;
  logic [TimerWidth-1:0]   fb_timer;
  logic                    fb_err;
  logic                    os_err;

  scan_item_t    scan_backlog[$];
  valve_status_t expected_status[$];
  int            status_faults;

  int   send_idle_pct;
  int   recv_idle_pct;
  logic hold_req;
  int   gap_wait;
  int   ready_wait;
  int   quiet_cycles;

  // Sensor levels for random scans; they change rarely so that feedback
  // stays wrong long enough for the timer to run out.
  logic press_lvl;
  logic pos_lvl;
  logic os_lvl;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void run_feedback_timer(input logic reload, input logic tick);
    if (reload) fb_timer = TimerWidth'(reload_ticks);
    if (tick && fb_timer != '0) fb_timer = fb_timer - 1'b1;
    if (fb_timer == '0) fb_err = 1'b1;
  endfunction

  function automatic valve_status_t advance_valve_scan(input scan_item_t s);
    valve_status_t r;
    // Requests latch according to the mode at the start of the scan.
    case (ctrl_mode)
      MODE_OPER: begin
        if (s.key_open) pending[P_OPEN] = 1'b1;
        if (s.key_close) pending[P_CLOSE] = 1'b1;
        if (s.key_ack_error) pending[P_ACK] = 1'b1;
        if (s.key_auto) pending[P_AUTO] = 1'b1;
      end
      MODE_AUTO: begin
        if (s.key_operator) pending[P_OPER] = 1'b1;
      end
      default: begin
        if (s.key_auto) pending[P_AUTO] = 1'b1;
      end
    endcase
    if (s.remote_request) pending[P_REMOTE] = 1'b1;

    if (ctrl_mode != MODE_AUTO) begin
      if (pending[P_OPEN]) begin
        pending[P_OPEN] = 1'b0;
        valve_open = 1'b1;
      end
      if (pending[P_CLOSE]) begin
        pending[P_CLOSE] = 1'b0;
        valve_open = 1'b0;
      end
      if (pending[P_AUTO]) begin
        pending[P_AUTO] = 1'b0;
        ctrl_mode = MODE_AUTO;
      end
      if (pending[P_ACK]) begin
        pending[P_ACK] = 1'b0;
        fb_err = 1'b0;
      end
    end else if (pending[P_OPER]) begin
      pending[P_OPER] = 1'b0;
      ctrl_mode = MODE_OPER;
    end else if (pending[P_REMOTE]) begin
      pending[P_REMOTE] = 1'b0;
      ctrl_mode = MODE_REMOTE;
    end

    if (press_chk_on) run_feedback_timer(valve_open ? s.press_sense : !s.press_sense,
                                         s.second_tick);
    if (pos_chk_on) run_feedback_timer(valve_open ? !s.position_sense : s.position_sense,
                                       s.second_tick);
    if (os_chk_on) os_err = !s.os_sense;

    r.drive_open = valve_open;
    r.mode = ctrl_mode;
    r.feedback_error = fb_err;
    r.os_error = os_err;
    return r;
  endfunction

  task automatic check_status(input valve_status_t got);
    valve_status_t want;
    if (expected_status.size() == 0) begin
      status_faults++;
      if (status_faults <= ReportLimit)
        $display("%0t: status with nothing expected: open=%0d mode=%0d fb=%0d os=%0d",
                 $realtime, got.drive_open, got.mode, got.feedback_error, got.os_error);
    end else begin
      want = expected_status.pop_front();
      if (got.drive_open !== want.drive_open || got.mode !== want.mode ||
          got.feedback_error !== want.feedback_error || got.os_error !== want.os_error) begin
        status_faults++;
        if (status_faults <= ReportLimit)
          $display("%0t: status mismatch: expected open=%0d mode=%0d fb=%0d os=%0d, %s",
                   $realtime, want.drive_open, want.mode, want.feedback_error,
                   want.os_error, $sformatf("got open=%0d mode=%0d fb=%0d os=%0d",
                   got.drive_open, got.mode, got.feedback_error, got.os_error));
      end
    end
  endtask

  always @(posedge clk) begin : monitor
    scan_item_t    seen;
    valve_status_t got;
    if (rst) begin
      reload_ticks = WaitReloadReset;
      press_chk_on = 1'b0;
      pos_chk_on = 1'b0;
      os_chk_on = 1'b0;
      valve_open = 1'b0;
      ctrl_mode = MODE_AUTO;
      pending = '0;
      fb_timer = TimerWidth'(TimerResetValue);
      fb_err = 1'b0;
      os_err = 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_WAIT_RELOAD:     reload_ticks = cfg_data;
          CFG_PRESS_ENABLE:    press_chk_on = cfg_data[0];
          CFG_POSITION_ENABLE: pos_chk_on = cfg_data[0];
          CFG_OS_ENABLE:       os_chk_on = cfg_data[0];
          default: ;
        endcase
      end
      if (scan_in_ch.valid && scan_in_ch.ready) begin
        seen.key_open = scan_in_ch.key_open;
        seen.key_close = scan_in_ch.key_close;
        seen.key_ack_error = scan_in_ch.key_ack_error;
        seen.key_auto = scan_in_ch.key_auto;
        seen.key_operator = scan_in_ch.key_operator;
        seen.remote_request = scan_in_ch.remote_request;
        seen.press_sense = scan_in_ch.press_sense;
        seen.position_sense = scan_in_ch.position_sense;
        seen.os_sense = scan_in_ch.os_sense;
        seen.second_tick = scan_in_ch.second_tick;
        expected_status.push_back(advance_valve_scan(seen));
      end
      if (scan_out_ch.valid && scan_out_ch.ready) begin
        got.drive_open = scan_out_ch.drive_open;
        got.mode = scan_out_ch.mode;
        got.feedback_error = scan_out_ch.feedback_error;
        got.os_error = scan_out_ch.os_error;
        check_status(got);
      end
    end
  end

  always @(posedge clk) begin : driver
    scan_item_t nxt;
    if (rst) begin
      scan_in_ch.valid <= 1'b0;
      gap_wait <= 0;
    end else if (!scan_in_ch.valid || scan_in_ch.ready) begin
      if (gap_wait != 0) begin
        gap_wait <= gap_wait - 1;
        scan_in_ch.valid <= 1'b0;
      end else if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
        gap_wait <= $urandom_range(0, 13);
        scan_in_ch.valid <= 1'b0;
      end else if (scan_backlog.size() != 0) begin
        nxt = scan_backlog.pop_front();
        scan_in_ch.key_open <= nxt.key_open;
        scan_in_ch.key_close <= nxt.key_close;
        scan_in_ch.key_ack_error <= nxt.key_ack_error;
        scan_in_ch.key_auto <= nxt.key_auto;
        scan_in_ch.key_operator <= nxt.key_operator;
        scan_in_ch.remote_request <= nxt.remote_request;
        scan_in_ch.press_sense <= nxt.press_sense;
        scan_in_ch.position_sense <= nxt.position_sense;
        scan_in_ch.os_sense <= nxt.os_sense;
        scan_in_ch.second_tick <= nxt.second_tick;
        scan_in_ch.valid <= 1'b1;
      end else begin
        scan_in_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : receiver
    if (rst) begin
      scan_out_ch.ready <= 1'b0;
      ready_wait <= 0;
    end else if (hold_req) begin
      scan_out_ch.ready <= 1'b0;
      ready_wait <= HoldOffCycles - 1;
    end else if (ready_wait != 0) begin
      ready_wait <= ready_wait - 1;
      scan_out_ch.ready <= 1'b0;
    end else if (recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct) begin
      scan_out_ch.ready <= 1'b0;
      ready_wait <= $urandom_range(0, 13);
    end else begin
      scan_out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((scan_in_ch.valid && scan_in_ch.ready) ||
                 (scan_out_ch.valid && scan_out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == StallLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic void queue_scan(input logic k_open, input logic k_close,
                                     input logic k_ack, input logic k_auto,
                                     input logic k_oper, input logic remote,
                                     input logic press, input logic pos,
                                     input logic os, input logic tick);
    scan_item_t s;
    s.key_open = k_open;
    s.key_close = k_close;
    s.key_ack_error = k_ack;
    s.key_auto = k_auto;
    s.key_operator = k_oper;
    s.remote_request = remote;
    s.press_sense = press;
    s.position_sense = pos;
    s.os_sense = os;
    s.second_tick = tick;
    scan_backlog.push_back(s);
  endfunction

  function automatic scan_item_t random_scan();
    scan_item_t s;
    if ($urandom_range(0, 5) == 0) press_lvl = ~press_lvl;
    if ($urandom_range(0, 5) == 0) pos_lvl = ~pos_lvl;
    if ($urandom_range(0, 7) == 0) os_lvl = ~os_lvl;
    s.key_open = ($urandom_range(0, 2) == 0);
    s.key_close = ($urandom_range(0, 2) == 0);
    s.key_ack_error = ($urandom_range(0, 3) == 0);
    s.key_auto = ($urandom_range(0, 7) == 0);
    s.key_operator = ($urandom_range(0, 3) == 0);
    s.remote_request = ($urandom_range(0, 7) == 0);
    s.press_sense = ($urandom_range(0, 15) == 0) ? ~press_lvl : press_lvl;
    s.position_sense = ($urandom_range(0, 15) == 0) ? ~pos_lvl : pos_lvl;
    s.os_sense = os_lvl;
    s.second_tick = ($urandom_range(0, 1) == 0);
    return s;
  endfunction

  // Writes every register; only called with the block idle.
  task automatic apply_settings(input logic [ReloadWidth-1:0] reload, input logic press_on,
                                input logic pos_on, input logic os_on);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_WAIT_RELOAD;
    cfg_data <= reload;
    @(posedge clk);
    cfg_index <= CFG_PRESS_ENABLE;
    cfg_data <= ReloadWidth'(press_on);
    @(posedge clk);
    cfg_index <= CFG_POSITION_ENABLE;
    cfg_data <= ReloadWidth'(pos_on);
    @(posedge clk);
    cfg_index <= CFG_OS_ENABLE;
    cfg_data <= ReloadWidth'(os_on);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (scan_backlog.size() != 0 || scan_in_ch.valid || expected_status.size() != 0);
  endtask

  initial begin
    logic [ReloadWidth-1:0] reload;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    scan_in_ch.valid = 1'b0;
    scan_in_ch.key_open = 1'b0;
    scan_in_ch.key_close = 1'b0;
    scan_in_ch.key_ack_error = 1'b0;
    scan_in_ch.key_auto = 1'b0;
    scan_in_ch.key_operator = 1'b0;
    scan_in_ch.remote_request = 1'b0;
    scan_in_ch.press_sense = 1'b0;
    scan_in_ch.position_sense = 1'b0;
    scan_in_ch.os_sense = 1'b0;
    scan_in_ch.second_tick = 1'b0;
    scan_out_ch.ready = 1'b0;
    hold_req = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    status_faults = 0;
    press_lvl = 1'b0;
    pos_lvl = 1'b1;
    os_lvl = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Mode handling with every check off.
    send_idle_pct = 20;
    recv_idle_pct = 20;
    queue_scan(0, 0, 0, 0, 0, 0, 0, 0, 1, 0);
    // Operator keys in auto mode are not latched at all.
    queue_scan(1, 1, 1, 1, 0, 0, 1, 1, 1, 1);
    queue_scan(0, 0, 0, 0, 1, 0, 0, 0, 1, 0);
    queue_scan(1, 0, 0, 0, 0, 0, 0, 0, 1, 0);
    queue_scan(0, 1, 0, 0, 0, 0, 0, 0, 1, 0);
    // Open and close together leave the valve closed.
    queue_scan(1, 1, 0, 0, 0, 0, 0, 0, 1, 0);
    // A remote request in operator mode waits until auto mode is back.
    queue_scan(1, 0, 0, 0, 0, 1, 0, 0, 1, 0);
    queue_scan(0, 0, 1, 0, 0, 0, 0, 0, 1, 0);
    queue_scan(0, 0, 0, 1, 0, 0, 0, 0, 1, 0);
    queue_scan(0, 0, 0, 0, 0, 0, 0, 0, 1, 0);
    queue_scan(1, 1, 1, 0, 1, 0, 1, 1, 0, 1);
    queue_scan(0, 0, 0, 1, 0, 0, 0, 0, 1, 0);
    // Operator beats remote in auto mode; remote stays latched.
    queue_scan(0, 0, 0, 0, 1, 1, 0, 0, 1, 0);
    queue_scan(0, 0, 0, 1, 0, 0, 0, 0, 1, 0);
    queue_scan(0, 0, 0, 0, 0, 0, 0, 0, 1, 0);
    queue_scan(1, 1, 1, 1, 1, 1, 1, 1, 1, 1);
    queue_scan(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    queue_scan(0, 0, 0, 1, 0, 0, 0, 0, 1, 0);
    wait_drained();

    // A zero reload trips the feedback error at once, and an acknowledge
    // cannot clear it while the timer sits at zero.
    apply_settings('0, 1'b1, 1'b1, 1'b1);
    queue_scan(0, 0, 0, 0, 0, 0, 0, 1, 0, 0);
    queue_scan(0, 0, 0, 0, 1, 0, 0, 0, 0, 1);
    queue_scan(0, 0, 1, 0, 0, 0, 0, 0, 0, 0);
    wait_drained();

    // Full reload with both timer checks: one tick counts down twice.
    // The OS flag holds its value with its check off.
    apply_settings('1, 1'b1, 1'b1, 1'b0);
    queue_scan(0, 0, 1, 0, 0, 0, 0, 1, 1, 1);
    queue_scan(0, 0, 0, 0, 0, 0, 1, 0, 1, 1);
    queue_scan(0, 0, 0, 1, 0, 0, 0, 0, 1, 0);
    wait_drained();

    for (int ph = 0; ph < RandomPhases; ph++) begin
      if (ph == 0) begin
        apply_settings('0, 1'b1, 1'b1, 1'b1);
      end else if (ph == 1) begin
        apply_settings('1, 1'b0, 1'b0, 1'b0);
      end else begin
        case ($urandom_range(0, 5))
          0:       reload = '0;
          1:       reload = '1;
          default: reload = ReloadWidth'($urandom_range(1, 12));
        endcase
        apply_settings(reload, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)));
      end
      if (ph == RandomPhases - 1) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (ph % 3 == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 25;
      end else begin
        send_idle_pct = 15;
        recv_idle_pct = (ph % 3 == 1) ? 0 : 15;
      end
      for (int n = 0; n < ScansPerPhase; n++) scan_backlog.push_back(random_scan());
      if (ph == 3) begin
        // Hold the result side off while scans keep coming, so the block backs up.
        hold_req = 1'b1;
        @(negedge clk);
        hold_req = 1'b0;
      end
      wait_drained();
    end

    repeat (4) @(posedge clk);
    if (status_faults == 0 && expected_status.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
